@@ hdl/matrix3x3_inverse_defines.svh @@
// ----------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Shared concurrent assertion forms on clock; same-cycle form off in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MI3_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, active during reset as well
`define MI3_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) (cond) |=> (prop)) else $error(msg);

`endif

@@ hdl/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, types and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int ElemW       = 16;   // Q4.12 input element
   localparam int ProdW       = 32;   // element product
   localparam int CofW        = 33;   // cofactor, units 2^-24
   localparam int DetW        = 49;   // determinant, units 2^-36
   localparam int MagW        = 48;   // determinant magnitude
   localparam int AdjMagW     = 32;   // cofactor magnitude
   localparam int NumW        = 60;   // dividend |adj| * 2^28 + |det| / 2
   localparam int QW          = 32;   // quotient bits
   localparam int NumHiW      = NumW - QW;
   localparam int EpsW        = 40;
   localparam int NumElem     = 9;
   localparam int CofStages   = 2;
   localparam int DetStages   = 4;
   localparam int DivStages   = QW + 2;
   localparam int NumStages   = CofStages + DetStages + DivStages;
   localparam int InDataW     = NumElem * ElemW;
   localparam int OutPayW     = NumElem * QW + DetW;
   localparam int OutDataW    = ((OutPayW + 7) / 8) * 8;

   localparam logic [EpsW-1:0] EpsReset = EpsW'(687195);
   localparam logic [QW-1:0]   QMaxPos  = 32'h7FFF_FFFF;
   localparam logic [QW-1:0]   QMinNeg  = 32'h8000_0000;

   typedef logic signed [ElemW-1:0]  elem_type;
   typedef logic signed [ProdW-1:0]  prod_type;
   typedef logic signed [CofW-1:0]   cof_type;
   typedef logic signed [DetW-1:0]   det_type;
   typedef logic        [MagW-1:0]   mag_type;
   typedef logic        [AdjMagW-1:0] adjmag_type;
   typedef logic        [NumW-1:0]   num_type;
   typedef logic        [QW-1:0]     quot_type;
   typedef logic        [EpsW-1:0]   eps_type;

   // one divider operand: dividend split at the quotient width, result sign
   typedef struct packed {
      logic [NumHiW-1:0] nhi;
      logic [QW-1:0]     nlo;
      logic              neg;
   } div_op_type;

endpackage

@@ hdl/matrix3x3_inverse.sv @@
// Throughput: one matrix per cycle while rsp_tready is held high; 2 product/cofactor stages,
// 4 determinant stages, 34 divider stages (overflow check, 32 quotient bits, sign/saturate).
// Each stage holds its own valid bit, so bubbles close up under back pressure.
// Reset (synchronous, active high) empties the pipeline and sets
// singular_epsilon to 687195.
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 matrix inverse by the adjugate: exact determinant, Q16.16 inverse.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_defines.svh"

module matrix3x3_inverse (
   input  logic                          clock,
   input  logic                          reset,
   // configuration: singular_epsilon
   input  logic                          csr_wr_en,
   input  logic [mi3_pkg::EpsW-1:0]      csr_wr_data,
   // input matrix: a00,a01,a02,a10,a11,a12,a20,a21,a22 (16 bits each)
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mi3_pkg::InDataW-1:0]   req_tdata,
   // result: inv00..inv22 (32 bits each), det_value (49 bits), zero pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mi3_pkg::OutDataW-1:0]  rsp_tdata,
   // result flag: singular
   output logic                          rsp_tuser
);

   localparam int NS = mi3_pkg::NumStages;
   localparam int C0 = mi3_pkg::CofStages;
   localparam int D0 = mi3_pkg::CofStages + mi3_pkg::DetStages;

   logic [NS-1:0]       valid_ff;
   logic [NS-1:0]       ready;
   mi3_pkg::eps_type    eps_ff;
   mi3_pkg::elem_type   a_in   [9];
   mi3_pkg::cof_type    cof    [9];
   mi3_pkg::elem_type   row0   [3];
   mi3_pkg::div_op_type op     [9];
   mi3_pkg::mag_type    den;
   logic                sing;
   mi3_pkg::det_type    det;
   mi3_pkg::quot_type   inv    [9];
   mi3_pkg::det_type    det_out;
   logic                sing_out;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= mi3_pkg::EpsReset;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // a stage takes new data when empty or when its successor takes its data
   assign ready[NS-1] = !valid_ff[NS-1] || rsp_tready;
   for (genvar s = 0; s < NS-1; s++) begin : g_ready
      assign ready[s] = !valid_ff[s] || ready[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= req_tvalid;
         for (int s = 1; s < NS; s++) begin
            if (ready[s]) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   assign req_tready = ready[0];

   // unpack input elements, a00 in the low bits
   for (genvar k = 0; k < 9; k++) begin : g_unpack
      assign a_in[k] = req_tdata[k*mi3_pkg::ElemW +: mi3_pkg::ElemW];
   end

   mi3_cofactor u_cofactor (
      .clock (clock),
      .en    (ready[C0-1:0]),
      .a_in  (a_in),
      .cof   (cof),
      .row0  (row0)
   );

   mi3_det u_det (
      .clock (clock),
      .en    (ready[D0-1:C0]),
      .cof   (cof),
      .row0  (row0),
      .eps   (eps_ff),
      .op    (op),
      .den   (den),
      .sing  (sing),
      .det   (det)
   );

   mi3_divider u_divider (
      .clock    (clock),
      .en       (ready[NS-1:D0]),
      .op       (op),
      .den      (den),
      .sing     (sing),
      .det      (det),
      .inv      (inv),
      .det_out  (det_out),
      .sing_out (sing_out)
   );

   // pack result
   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < 9; k++) begin
         rsp_tdata[k*mi3_pkg::QW +: mi3_pkg::QW] = inv[k];
      end
      rsp_tdata[9*mi3_pkg::QW +: mi3_pkg::DetW] = det_out;
   end

   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tuser  = sing_out;

   // checks
   `MI3_ASSERT_IMP(a_sing_zero, rsp_tvalid && sing_out, rsp_tdata[9*mi3_pkg::QW-1:0] == '0, "singular result carries nonzero inverse")
   `MI3_ASSERT_IMP(a_det_zero_sing, rsp_tvalid && (det_out == '0), sing_out, "zero determinant not flagged singular")
   `MI3_ASSERT_NXT(a_reset_empty, reset, valid_ff == '0, "pipeline not empty after reset")
   `MI3_ASSERT_IMP(a_full_stall, (&valid_ff) && !rsp_tready, !req_tready, "input taken while pipeline full and stalled")

endmodule

@@ hdl/mi3_cofactor.sv @@
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the 18 minor products, then the nine signed cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor (
   input  logic               clock,
   input  logic [1:0]         en,
   input  mi3_pkg::elem_type  a_in   [9],
   output mi3_pkg::cof_type   cof    [9],
   output mi3_pkg::elem_type  row0   [3]
);

   mi3_pkg::prod_type pp_ff  [9];
   mi3_pkg::prod_type pn_ff  [9];
   mi3_pkg::cof_type  cof_ff [9];
   mi3_pkg::elem_type row0_s0_ff [3];
   mi3_pkg::elem_type row0_s1_ff [3];

   // cofactor (r,c): minor over the other rows r1<r2 and columns c1<c2
   for (genvar k = 0; k < 9; k++) begin : g_cof
      localparam int R  = k / 3;
      localparam int C  = k % 3;
      localparam int R1 = (R == 0) ? 1 : 0;
      localparam int R2 = (R == 2) ? 1 : 2;
      localparam int C1 = (C == 0) ? 1 : 0;
      localparam int C2 = (C == 2) ? 1 : 2;
      localparam int Odd = (R + C) % 2;

      // products
      always_ff @(posedge clock) begin
         if (en[0]) begin
            pp_ff[k] <= a_in[R1*3 + C1] * a_in[R2*3 + C2];
            pn_ff[k] <= a_in[R1*3 + C2] * a_in[R2*3 + C1];
         end
      end

      // difference, checkerboard sign folded into operand order
      always_ff @(posedge clock) begin
         if (en[1]) begin
            if (Odd == 1) begin
               cof_ff[k] <= mi3_pkg::cof_type'(pn_ff[k]) - mi3_pkg::cof_type'(pp_ff[k]);
            end else begin
               cof_ff[k] <= mi3_pkg::cof_type'(pp_ff[k]) - mi3_pkg::cof_type'(pn_ff[k]);
            end
         end
      end

      assign cof[k] = cof_ff[k];
   end

   // row 0 travels along for the determinant expansion
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < 3; j++) row0_s0_ff[j] <= a_in[j];
      end
      if (en[1]) begin
         for (int j = 0; j < 3; j++) row0_s1_ff[j] <= row0_s0_ff[j];
      end
   end

   assign row0 = row0_s1_ff;

endmodule

@@ hdl/mi3_det.sv @@
// ----------------------------------------------------------------------------
// mi3_det
// Four stages: determinant products, sum, magnitude, then the singular
// test and the rounded dividends for the nine adjugate elements.
// ----------------------------------------------------------------------------
module mi3_det (
   input  logic                 clock,
   input  logic [3:0]           en,
   input  mi3_pkg::cof_type     cof  [9],
   input  mi3_pkg::elem_type    row0 [3],
   input  mi3_pkg::eps_type     eps,
   output mi3_pkg::div_op_type  op   [9],
   output mi3_pkg::mag_type     den,
   output logic                 sing,
   output mi3_pkg::det_type     det
);

   mi3_pkg::det_type    dp_ff [3];
   mi3_pkg::adjmag_type adjmag_a_ff [9];
   mi3_pkg::adjmag_type adjmag_b_ff [9];
   mi3_pkg::adjmag_type adjmag_c_ff [9];
   logic                adjneg_a_ff [9];
   logic                adjneg_b_ff [9];
   logic                adjneg_c_ff [9];
   mi3_pkg::det_type    det_b_ff;
   mi3_pkg::det_type    det_c_ff;
   mi3_pkg::det_type    det_d_ff;
   mi3_pkg::mag_type    dmag_c_ff;
   mi3_pkg::mag_type    dmag_d_ff;
   logic                dneg_c_ff;
   logic                dzero_c_ff;
   logic                sing_d_ff;
   mi3_pkg::div_op_type op_d_ff [9];
   mi3_pkg::num_type    num [9];

   // stage A: expansion along row 0, transpose into adjugate order
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < 3; j++) dp_ff[j] <= row0[j] * cof[j];
         for (int i = 0; i < 9; i++) begin
            adjneg_a_ff[i] <= cof[(i % 3) * 3 + i / 3][mi3_pkg::CofW-1];
            adjmag_a_ff[i] <= mi3_pkg::adjmag_type'(cof[(i % 3) * 3 + i / 3][mi3_pkg::CofW-1]
                                ? -cof[(i % 3) * 3 + i / 3] : cof[(i % 3) * 3 + i / 3]);
         end
      end
   end

   // stage B: determinant sum
   always_ff @(posedge clock) begin
      if (en[1]) begin
         det_b_ff <= dp_ff[0] + dp_ff[1] + dp_ff[2];
         adjmag_b_ff <= adjmag_a_ff;
         adjneg_b_ff <= adjneg_a_ff;
      end
   end

   // stage C: determinant magnitude and sign
   always_ff @(posedge clock) begin
      if (en[2]) begin
         dmag_c_ff  <= mi3_pkg::mag_type'(det_b_ff[mi3_pkg::DetW-1] ? -det_b_ff : det_b_ff);
         dneg_c_ff  <= det_b_ff[mi3_pkg::DetW-1];
         dzero_c_ff <= (det_b_ff == '0);
         det_c_ff   <= det_b_ff;
         adjmag_c_ff <= adjmag_b_ff;
         adjneg_c_ff <= adjneg_b_ff;
      end
   end

   // dividend with half the divisor added for round half away from zero
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         num[i] = {adjmag_c_ff[i], {(mi3_pkg::NumW - mi3_pkg::AdjMagW){1'b0}}}
                  + mi3_pkg::num_type'(dmag_c_ff >> 1);
      end
   end

   // stage D: singular test and divider operands
   always_ff @(posedge clock) begin
      if (en[3]) begin
         sing_d_ff <= dzero_c_ff || (dmag_c_ff < mi3_pkg::mag_type'(eps));
         dmag_d_ff <= dmag_c_ff;
         det_d_ff  <= det_c_ff;
         for (int i = 0; i < 9; i++) begin
            op_d_ff[i].nhi <= num[i][mi3_pkg::NumW-1:mi3_pkg::QW];
            op_d_ff[i].nlo <= num[i][mi3_pkg::QW-1:0];
            op_d_ff[i].neg <= adjneg_c_ff[i] ^ dneg_c_ff;
         end
      end
   end

   assign op   = op_d_ff;
   assign den  = dmag_d_ff;
   assign sing = sing_d_ff;
   assign det  = det_d_ff;

endmodule

@@ hdl/mi3_divider.sv @@
// ----------------------------------------------------------------------------
// mi3_divider
// Nine restoring dividers sharing one divisor: an overflow check stage, one
// quotient bit per stage, and a sign/saturate output stage.
// ----------------------------------------------------------------------------
module mi3_divider (
   input  logic                 clock,
   input  logic [mi3_pkg::DivStages-1:0] en,
   input  mi3_pkg::div_op_type  op  [9],
   input  mi3_pkg::mag_type     den,
   input  logic                 sing,
   input  mi3_pkg::det_type     det,
   output mi3_pkg::quot_type    inv [9],
   output mi3_pkg::det_type     det_out,
   output logic                 sing_out
);

   localparam int Steps = mi3_pkg::QW;

   mi3_pkg::mag_type  r_ff   [Steps+1][9];
   mi3_pkg::quot_type nq_ff  [Steps+1][9];
   logic              ovf_ff [Steps+1][9];
   logic              neg_ff [Steps+1][9];
   mi3_pkg::mag_type  den_ff [Steps+1];
   logic              sing_ff[Steps+1];
   mi3_pkg::det_type  det_ff [Steps+1];
   mi3_pkg::quot_type inv_ff [9];
   mi3_pkg::det_type  det_o_ff;
   logic              sing_o_ff;

   // entry: quotient overflows 32 bits when the high dividend part >= divisor
   always_ff @(posedge clock) begin
      if (en[0]) begin
         den_ff[0]  <= den;
         sing_ff[0] <= sing;
         det_ff[0]  <= det;
         for (int i = 0; i < 9; i++) begin
            r_ff[0][i]   <= mi3_pkg::mag_type'(op[i].nhi);
            ovf_ff[0][i] <= (mi3_pkg::mag_type'(op[i].nhi) >= den);
            nq_ff[0][i]  <= op[i].nlo;
            neg_ff[0][i] <= op[i].neg;
         end
      end
   end

   // one quotient bit per stage; nq shifts dividend bits out, quotient in
   for (genvar s = 1; s <= Steps; s++) begin : g_step
      logic [mi3_pkg::MagW:0] t  [9];
      logic                   ge [9];

      always_comb begin
         for (int i = 0; i < 9; i++) begin
            t[i]  = {r_ff[s-1][i], nq_ff[s-1][i][mi3_pkg::QW-1]};
            ge[i] = (t[i] >= {1'b0, den_ff[s-1]});
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            den_ff[s]  <= den_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
            det_ff[s]  <= det_ff[s-1];
            for (int i = 0; i < 9; i++) begin
               r_ff[s][i]   <= ge[i] ? mi3_pkg::mag_type'(t[i] - {1'b0, den_ff[s-1]})
                                     : t[i][mi3_pkg::MagW-1:0];
               nq_ff[s][i]  <= {nq_ff[s-1][i][mi3_pkg::QW-2:0], ge[i]};
               ovf_ff[s][i] <= ovf_ff[s-1][i];
               neg_ff[s][i] <= neg_ff[s-1][i];
            end
         end
      end
   end

   // sign, saturation and singular masking
   always_ff @(posedge clock) begin
      if (en[Steps+1]) begin
         det_o_ff  <= det_ff[Steps];
         sing_o_ff <= sing_ff[Steps];
         for (int i = 0; i < 9; i++) begin
            if (sing_ff[Steps]) begin
               inv_ff[i] <= '0;
            end else if (ovf_ff[Steps][i] || nq_ff[Steps][i][mi3_pkg::QW-1]) begin
               inv_ff[i] <= neg_ff[Steps][i] ? mi3_pkg::QMinNeg : mi3_pkg::QMaxPos;
            end else if (neg_ff[Steps][i]) begin
               inv_ff[i] <= -nq_ff[Steps][i];
            end else begin
               inv_ff[i] <= nq_ff[Steps][i];
            end
         end
      end
   end

   assign inv      = inv_ff;
   assign det_out  = det_o_ff;
   assign sing_out = sing_o_ff;

endmodule
